FILE: rtl/core/elar_pkg.sv
// shared constants and types for the lever arm rotation block
package elar_pkg;

   // cordic constants in q16
   localparam int CordicSteps = 16;
   localparam logic signed [19:0] CordicGain = 20'sd39797;
   localparam logic signed [19:0] PiQ16 = 20'sd205887;
   localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;

   // working width of a cordic datapath value
   localparam int CordicWidth = 20;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_LEVER_X = 2'd0,
      REG_LEVER_Y = 2'd1,
      REG_LEVER_Z = 2'd2
   } reg_index_type;

   // arctangent table, q16
   function automatic logic signed [19:0] atan_q16(input logic [3:0] idx);
      logic signed [19:0] val;
      case (idx)
         4'd0: val = 20'sd51472;
         4'd1: val = 20'sd30386;
         4'd2: val = 20'sd16055;
         4'd3: val = 20'sd8150;
         4'd4: val = 20'sd4091;
         4'd5: val = 20'sd2047;
         4'd6: val = 20'sd1024;
         4'd7: val = 20'sd512;
         4'd8: val = 20'sd256;
         4'd9: val = 20'sd128;
         4'd10: val = 20'sd64;
         4'd11: val = 20'sd32;
         4'd12: val = 20'sd16;
         4'd13: val = 20'sd8;
         4'd14: val = 20'sd4;
         default: val = 20'sd2;
      endcase
      return val;
   endfunction

   // one cordic state: cosine, sine, residual angle
   typedef struct packed {
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic signed [19:0] z;
      logic               neg;
   } cordic_type;

   // q16 product, rounded half up
   function automatic logic signed [19:0] mulq(input logic signed [19:0] a,
                                               input logic signed [19:0] b);
      logic signed [39:0] p;
      p = 40'(a) * 40'(b) + 40'sd32768;
      return 20'(p >>> 16);
   endfunction

endpackage

FILE: rtl/core/euler_lever_arm_rotation.sv
// Lever arm rotation from body frame to NED with a ZYX Euler matrix.
// Fully pipelined: one transaction may enter every clock unless the result side
// is stalled. There are 23 register stages: one range-reduction stage, sixteen
// CORDIC stages, three matrix stages, one lever product stage, one row sum stage
// and one output register. Latency is set by the CORDIC iteration count; a stall
// on the result side holds the whole pipeline, and ready falls only then.
module euler_lever_arm_rotation #(
   parameter int ANGLE_WIDTH    = 16,
   parameter int POSITION_WIDTH = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [ANGLE_WIDTH-1:0]    req_roll_angle,
   input  logic signed [ANGLE_WIDTH-1:0]    req_pitch_angle,
   input  logic signed [ANGLE_WIDTH-1:0]    req_yaw_angle,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [POSITION_WIDTH:0]   rsp_offset_north,
   output logic signed [POSITION_WIDTH:0]   rsp_offset_east,
   output logic signed [POSITION_WIDTH:0]   rsp_offset_down,
   input  logic                             csr_write_enable,
   input  logic [1:0]                       csr_index,
   input  logic [POSITION_WIDTH-1:0]        csr_write_data
);

   localparam int Steps = elar_pkg::CordicSteps;
   localparam int Frac = ANGLE_WIDTH - 3;
   localparam int Cw = elar_pkg::CordicWidth;
   localparam int AccW = Cw + POSITION_WIDTH + 3;
   localparam int Depth = Steps + 7;

   // global pipeline advance: hold everything while the result is stalled
   logic advance;
   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // configuration registers
   logic signed [POSITION_WIDTH-1:0] lever_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         lever_ff[0] <= '0;
         lever_ff[1] <= '0;
         lever_ff[2] <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            elar_pkg::REG_LEVER_X: lever_ff[0] <= csr_write_data;
            elar_pkg::REG_LEVER_Y: lever_ff[1] <= csr_write_data;
            elar_pkg::REG_LEVER_Z: lever_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // valid bits travel with data
   logic [Depth-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[Depth-2:0], req_valid};
   end

   // angle to q16
   function automatic logic signed [Cw-1:0] to_q16(input logic signed [ANGLE_WIDTH-1:0] a);
      logic signed [Cw+ANGLE_WIDTH-1:0] w;
      w = (Cw+ANGLE_WIDTH)'(a);
      if (Frac <= 16) return Cw'(w <<< (16 - Frac));
      else return Cw'(w >>> (Frac - 16));
   endfunction

   // range reduction stage
   elar_pkg::cordic_type cs_ff [3][Steps+1];
   logic signed [Cw-1:0] ang [3];
   assign ang[0] = to_q16(req_roll_angle);
   assign ang[1] = to_q16(req_pitch_angle);
   assign ang[2] = to_q16(req_yaw_angle);

   for (genvar a = 0; a < 3; a++) begin : g_axis
      always_ff @(posedge clock) begin
         if (advance) begin
            cs_ff[a][0].x <= elar_pkg::CordicGain;
            cs_ff[a][0].y <= '0;
            if (ang[a] > elar_pkg::HalfPiQ16) begin
               cs_ff[a][0].z <= ang[a] - elar_pkg::PiQ16;
               cs_ff[a][0].neg <= 1'b1;
            end else if (ang[a] < -elar_pkg::HalfPiQ16) begin
               cs_ff[a][0].z <= ang[a] + elar_pkg::PiQ16;
               cs_ff[a][0].neg <= 1'b1;
            end else begin
               cs_ff[a][0].z <= ang[a];
               cs_ff[a][0].neg <= 1'b0;
            end
         end
      end
      // one cordic iteration per stage
      for (genvar i = 0; i < Steps; i++) begin : g_step
         always_ff @(posedge clock) begin
            if (advance) begin
               cs_ff[a][i+1].neg <= cs_ff[a][i].neg;
               if (!cs_ff[a][i].z[Cw-1]) begin
                  cs_ff[a][i+1].x <= cs_ff[a][i].x - (cs_ff[a][i].y >>> i);
                  cs_ff[a][i+1].y <= cs_ff[a][i].y + (cs_ff[a][i].x >>> i);
                  cs_ff[a][i+1].z <= cs_ff[a][i].z - elar_pkg::atan_q16(4'(i));
               end else begin
                  cs_ff[a][i+1].x <= cs_ff[a][i].x + (cs_ff[a][i].y >>> i);
                  cs_ff[a][i+1].y <= cs_ff[a][i].y - (cs_ff[a][i].x >>> i);
                  cs_ff[a][i+1].z <= cs_ff[a][i].z + elar_pkg::atan_q16(4'(i));
               end
            end
         end
      end
   end

   // final sine/cosine with sign fold
   logic signed [Cw-1:0] sr, cr, sp, cp, sy, cy;
   always_comb begin
      cr = cs_ff[0][Steps].neg ? -cs_ff[0][Steps].x : cs_ff[0][Steps].x;
      sr = cs_ff[0][Steps].neg ? -cs_ff[0][Steps].y : cs_ff[0][Steps].y;
      cp = cs_ff[1][Steps].neg ? -cs_ff[1][Steps].x : cs_ff[1][Steps].x;
      sp = cs_ff[1][Steps].neg ? -cs_ff[1][Steps].y : cs_ff[1][Steps].y;
      cy = cs_ff[2][Steps].neg ? -cs_ff[2][Steps].x : cs_ff[2][Steps].x;
      sy = cs_ff[2][Steps].neg ? -cs_ff[2][Steps].y : cs_ff[2][Steps].y;
   end

   // first products
   logic signed [Cw-1:0] p_ff [10];
   logic signed [Cw-1:0] sr1_ff, cr1_ff, cy1_ff;
   logic signed [Cw-1:0] r21_ff0, r22_ff0;
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= elar_pkg::mulq(cy, cp);
         p_ff[1] <= elar_pkg::mulq(cy, sp);
         p_ff[2] <= elar_pkg::mulq(sy, cr);
         p_ff[3] <= elar_pkg::mulq(cr, sp);
         p_ff[4] <= elar_pkg::mulq(sy, sr);
         p_ff[5] <= elar_pkg::mulq(sy, cp);
         p_ff[6] <= elar_pkg::mulq(sy, sp);
         p_ff[7] <= elar_pkg::mulq(cy, cr);
         p_ff[8] <= elar_pkg::mulq(cy, sr);
         p_ff[9] <= -sp;
         sr1_ff <= sr;
         cr1_ff <= cr;
         cy1_ff <= cy;
         r21_ff0 <= elar_pkg::mulq(cp, sr);
         r22_ff0 <= elar_pkg::mulq(cp, cr);
      end
   end

   // second products
   logic signed [Cw-1:0] q_ff [4];
   logic signed [Cw-1:0] hold_ff [8];
   logic signed [Cw-1:0] r22_ff1;
   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff[0] <= elar_pkg::mulq(p_ff[1], sr1_ff);
         q_ff[1] <= elar_pkg::mulq(p_ff[3], cy1_ff);
         q_ff[2] <= elar_pkg::mulq(p_ff[6], sr1_ff);
         q_ff[3] <= elar_pkg::mulq(p_ff[6], cr1_ff);
         hold_ff[0] <= p_ff[0];
         hold_ff[1] <= p_ff[2];
         hold_ff[2] <= p_ff[4];
         hold_ff[3] <= p_ff[5];
         hold_ff[4] <= p_ff[7];
         hold_ff[5] <= p_ff[8];
         hold_ff[6] <= p_ff[9];
         hold_ff[7] <= r21_ff0;
         r22_ff1 <= r22_ff0;
      end
   end

   // matrix elements
   logic signed [Cw:0] r_ff [9];
   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff[0] <= (Cw+1)'(hold_ff[0]);
         r_ff[1] <= (Cw+1)'(q_ff[0]) - (Cw+1)'(hold_ff[1]);
         r_ff[2] <= (Cw+1)'(q_ff[1]) + (Cw+1)'(hold_ff[2]);
         r_ff[3] <= (Cw+1)'(hold_ff[3]);
         r_ff[4] <= (Cw+1)'(q_ff[2]) + (Cw+1)'(hold_ff[4]);
         r_ff[5] <= (Cw+1)'(q_ff[3]) - (Cw+1)'(hold_ff[5]);
         r_ff[6] <= (Cw+1)'(hold_ff[6]);
         r_ff[7] <= (Cw+1)'(hold_ff[7]);
         r_ff[8] <= (Cw+1)'(r22_ff1);
      end
   end

   // lever products, one multiplier each
   logic signed [AccW-1:0] m_ff [9];
   for (genvar k = 0; k < 9; k++) begin : g_mul
      always_ff @(posedge clock) begin
         if (advance) m_ff[k] <= AccW'(r_ff[k]) * AccW'(lever_ff[k % 3]);
      end
   end

   // row sums
   logic signed [AccW-1:0] s_ff [3];
   for (genvar r = 0; r < 3; r++) begin : g_sum
      always_ff @(posedge clock) begin
         if (advance) s_ff[r] <= m_ff[3*r] + m_ff[3*r+1] + m_ff[3*r+2] + AccW'(32768);
      end
   end

   // round and saturate
   localparam logic signed [AccW-1:0] Hi = AccW'((64'sd1 <<< POSITION_WIDTH) - 1);
   localparam logic signed [AccW-1:0] Lo = AccW'(-(64'sd1 <<< POSITION_WIDTH));
   logic signed [AccW-1:0] rnd [3];
   logic signed [POSITION_WIDTH:0] sat [3];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rnd[r] = s_ff[r] >>> 16;
         if (rnd[r] > Hi) sat[r] = Hi[POSITION_WIDTH:0];
         else if (rnd[r] < Lo) sat[r] = Lo[POSITION_WIDTH:0];
         else sat[r] = rnd[r][POSITION_WIDTH:0];
      end
   end

   // output register
   logic signed [POSITION_WIDTH:0] out_ff [3];
   always_ff @(posedge clock) begin
      if (advance) out_ff <= sat;
   end
   assign rsp_valid = vld_ff[Depth-1];
   assign rsp_offset_north = out_ff[0];
   assign rsp_offset_east = out_ff[1];
   assign rsp_offset_down = out_ff[2];

`ifndef SYNTHESIS
   // stalled result keeps its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_offset_north) && $stable(vld_ff))
      else $error("pipeline moved during stall");
   // ready only withheld by a stalled result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("ready dropped without stall");
   // accepted transaction shows up in first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("transaction lost at entry");
`endif

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the euler lever arm rotation block
`timescale 1ns / 100ps

module testbench;

   localparam int AngleWidth = 16;
   localparam int PosWidth = 24;
   localparam int PipeLatency = 23;
   localparam int SettleCycles = 40;
   localparam int WatchdogLimit = 5000;
   localparam int HoldCycles = 300;
   localparam int PhaseItems = 236;
   localparam logic [1:0] RegUnused = 2'd3;
   localparam longint GainQ16 = 39797;
   localparam longint PiLong = 205887;
   localparam longint HalfPiLong = 102944;
   localparam longint AtanTable [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
      512, 256, 128, 64, 32, 16, 8, 4, 2};

   typedef struct {
      logic signed [PosWidth:0] north;
      logic signed [PosWidth:0] east;
      logic signed [PosWidth:0] down;
   } offset_type;

   typedef struct {
      logic [AngleWidth-1:0] roll;
      logic [AngleWidth-1:0] pitch;
      logic [AngleWidth-1:0] yaw;
      offset_type            at_reset;
   } attitude_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [AngleWidth-1:0] req_roll_angle = '0;
   logic signed [AngleWidth-1:0] req_pitch_angle = '0;
   logic signed [AngleWidth-1:0] req_yaw_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [PosWidth:0] rsp_offset_north;
   logic signed [PosWidth:0] rsp_offset_east;
   logic signed [PosWidth:0] rsp_offset_down;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [PosWidth-1:0] csr_write_data = '0;

   // lever arm copy kept beside the block
   longint arm_x = 0;
   longint arm_y = 0;
   longint arm_z = 0;

   offset_type offset_queue[$];
   offset_type table_offset;
   bit use_table_offset = 0;
   bit no_idle = 0;
   bit hold_request = 0;
   int errors = 0;
   int quiet_cycles = 0;

   attitude_row_type attitude_rows [10];

   euler_lever_arm_rotation #(
      .ANGLE_WIDTH(AngleWidth),
      .POSITION_WIDTH(PosWidth)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_roll_angle(req_roll_angle),
      .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle(req_yaw_angle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_offset_north(rsp_offset_north),
      .rsp_offset_east(rsp_offset_east),
      .rsp_offset_down(rsp_offset_down),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // cordic sine and cosine of one angle, q16
   function automatic void angle_sin_cos(input logic [AngleWidth-1:0] raw,
                                         output longint s, output longint c);
      longint z, x, y, dx, dy;
      bit neg;
      z = longint'($signed(raw)) * 8;
      neg = 0;
      if (z > HalfPiLong) begin
         z = z - PiLong;
         neg = 1;
      end else if (z < -HalfPiLong) begin
         z = z + PiLong;
         neg = 1;
      end
      x = GainQ16;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - AtanTable[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + AtanTable[i];
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic longint q16_product(input longint a, input longint b);
      return (a * b + 32768) >>> 16;
   endfunction

   function automatic logic signed [PosWidth:0] round_saturate(input longint acc);
      longint v;
      v = (acc + 32768) >>> 16;
      if (v > (longint'(1) << PosWidth) - 1) v = (longint'(1) << PosWidth) - 1;
      if (v < -(longint'(1) << PosWidth)) v = -(longint'(1) << PosWidth);
      return v[PosWidth:0];
   endfunction

   // rotate the lever arm by one attitude
   function automatic offset_type rotate_lever_arm(input logic [AngleWidth-1:0] roll,
                                                   input logic [AngleWidth-1:0] pitch,
                                                   input logic [AngleWidth-1:0] yaw);
      longint sr, cr, sp, cp, sy, cy;
      longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
      offset_type o;
      angle_sin_cos(roll, sr, cr);
      angle_sin_cos(pitch, sp, cp);
      angle_sin_cos(yaw, sy, cy);
      r00 = q16_product(cy, cp);
      r01 = q16_product(q16_product(cy, sp), sr) - q16_product(sy, cr);
      r02 = q16_product(q16_product(cr, sp), cy) + q16_product(sy, sr);
      r10 = q16_product(sy, cp);
      r11 = q16_product(q16_product(sy, sp), sr) + q16_product(cy, cr);
      r12 = q16_product(q16_product(sy, sp), cr) - q16_product(cy, sr);
      r20 = -sp;
      r21 = q16_product(cp, sr);
      r22 = q16_product(cp, cr);
      o.north = round_saturate(r00 * arm_x + r01 * arm_y + r02 * arm_z);
      o.east = round_saturate(r10 * arm_x + r11 * arm_y + r12 * arm_z);
      o.down = round_saturate(r20 * arm_x + r21 * arm_y + r22 * arm_z);
      return o;
   endfunction

   // register write, mirrored into the lever arm copy
   task automatic write_lever(input logic [1:0] idx, input logic [PosWidth-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      case (idx)
         elar_pkg::REG_LEVER_X: arm_x = longint'($signed(data));
         elar_pkg::REG_LEVER_Y: arm_y = longint'($signed(data));
         elar_pkg::REG_LEVER_Z: arm_z = longint'($signed(data));
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_lever_arm(input logic [PosWidth-1:0] x, input logic [PosWidth-1:0] y,
                                input logic [PosWidth-1:0] z);
      write_lever(elar_pkg::REG_LEVER_X, x);
      write_lever(elar_pkg::REG_LEVER_Y, y);
      write_lever(elar_pkg::REG_LEVER_Z, z);
   endtask

   task automatic wait_drained();
      while (offset_queue.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // offer one attitude transaction and wait for its acceptance
   task automatic send_attitude(input logic [AngleWidth-1:0] roll,
                                input logic [AngleWidth-1:0] pitch,
                                input logic [AngleWidth-1:0] yaw);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 8) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_roll_angle = roll;
      req_pitch_angle = pitch;
      req_yaw_angle = yaw;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic logic [AngleWidth-1:0] random_angle();
      int near;
      case ($urandom_range(0, 7))
         0: return AngleWidth'($urandom);
         1: begin
            near = 12868 + $urandom_range(0, 2) - 1;
            return AngleWidth'($urandom_range(0, 1) ? near : -near);
         end
         default: return AngleWidth'($urandom_range(0, 51472) - 25736);
      endcase
   endfunction

   // predictor feed on each accepted attitude transaction
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (use_table_offset) offset_queue.push_back(table_offset);
         else offset_queue.push_back(rotate_lever_arm(req_roll_angle, req_pitch_angle,
                                                      req_yaw_angle));
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      offset_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (offset_queue.size() == 0) begin
            $display("%0t: unexpected result n=%0d e=%0d d=%0d", $time,
                     rsp_offset_north, rsp_offset_east, rsp_offset_down);
            errors++;
         end else begin
            want = offset_queue.pop_front();
            if (rsp_offset_north !== want.north) begin
               $display("%0t: north expected %0d actual %0d", $time, want.north,
                        rsp_offset_north);
               errors++;
            end
            if (rsp_offset_east !== want.east) begin
               $display("%0t: east expected %0d actual %0d", $time, want.east,
                        rsp_offset_east);
               errors++;
            end
            if (rsp_offset_down !== want.down) begin
               $display("%0t: down expected %0d actual %0d", $time, want.down,
                        rsp_offset_down);
               errors++;
            end
         end
      end
   end

   // result side readiness, with one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = (no_idle || $urandom_range(0, 99) >= 8);
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      offset_type zero_offset;
      zero_offset = '{north: '0, east: '0, down: '0};
      attitude_rows = '{
         '{16'sd0, 16'sd0, 16'sd0, zero_offset},
         '{16'sd25736, 16'sd0, 16'sd0, zero_offset},
         '{-16'sd25736, 16'sd0, 16'sd0, zero_offset},
         '{16'sd0, 16'sd25736, 16'sd0, zero_offset},
         '{16'sd0, -16'sd25736, 16'sd0, zero_offset},
         '{16'sd0, 16'sd0, 16'sd25736, zero_offset},
         '{16'sd0, 16'sd0, -16'sd25736, zero_offset},
         '{16'sd12868, 16'sd12869, -16'sd12869, zero_offset},
         '{16'sd32767, 16'sh8000, 16'sd32767, zero_offset},
         '{16'sh8000, 16'sd32767, 16'sh8000, zero_offset}
      };
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: lever arm still at reset, every offset is zero
      use_table_offset = 1;
      foreach (attitude_rows[i]) begin
         @(negedge clock);
         table_offset = attitude_rows[i].at_reset;
         send_attitude(attitude_rows[i].roll, attitude_rows[i].pitch, attitude_rows[i].yaw);
      end
      end_burst();
      use_table_offset = 0;
      wait_drained();

      // directed: extreme lever arms, unknown index must be ignored
      set_lever_arm(24'h7fffff, 24'h7fffff, 24'h7fffff);
      write_lever(RegUnused, 24'h123456);
      for (int i = 1; i < 10; i += 2)
         send_attitude(attitude_rows[i].roll, attitude_rows[i].pitch, attitude_rows[i].yaw);
      end_burst();
      wait_drained();
      set_lever_arm(24'h800000, 24'h800000, 24'h800000);
      for (int i = 0; i < 10; i += 2)
         send_attitude(attitude_rows[i].roll, attitude_rows[i].pitch, attitude_rows[i].yaw);
      end_burst();
      wait_drained();

      // random phases, one lever arm setting each
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_lever_arm(24'h7fffff, 24'h800000, 24'h7fffff);
            1: set_lever_arm(24'h800000, 24'h7fffff, 24'h000000);
            default: set_lever_arm(24'($urandom), 24'($urandom), 24'($urandom));
         endcase
         if (phase == 4) write_lever(RegUnused, 24'($urandom));
         no_idle = (phase == 2);
         for (int n = 0; n < PhaseItems; n++) begin
            if (phase == 3 && n == 20) hold_request = 1;
            if (phase == 5 && n == 100) begin
               end_burst();
               while (offset_queue.size() != 0) @(posedge clock);
            end
            send_attitude(random_angle(), random_angle(), random_angle());
         end
         end_burst();
         no_idle = 0;
         wait_drained();
      end

      repeat (PipeLatency) @(posedge clock);
      if (errors == 0 && offset_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
